/* design/at_response_line_parser_unit_macros.svh */
// assertion macros used by the at response line parser top level
`ifndef AT_RESPONSE_LINE_PARSER_UNIT_MACROS_SVH
`define AT_RESPONSE_LINE_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ATRLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ATRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/atrlp_pkg.sv */
// types, codes and character constants of the at response line parser
package atrlp_pkg;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_START   = 2'd1,
        OP_TICK    = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_ERROR   = 2'd1,
        STAT_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_READ   = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        CFG_PREFIX_BYTES  = 3'd0,
        CFG_PREFIX_LENGTH = 3'd1,
        CFG_ECHO_BYTES    = 3'd2,
        CFG_ECHO_LENGTH   = 3'd3,
        CFG_TIMEOUT_TICKS = 3'd4,
        CFG_COPY_LIMIT    = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_COPY,
        S_CR,
        S_LF,
        S_RDATA,
        S_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic echo;
        logic prefix;
        logic ok;
        logic err;
        logic cme;
        logic cms;
    } match_t;

    localparam logic [7:0]  CHAR_CR           = 8'h0D;
    localparam logic [7:0]  CHAR_LF           = 8'h0A;
    localparam logic [3:0]  OK_LEN            = 4'd2;
    localparam logic [3:0]  ERR_LEN           = 4'd5;
    localparam logic [3:0]  CMX_LEN           = 4'd11;
    localparam logic [3:0]  MAX_TEXT_LEN      = 4'd8;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
    localparam logic [8:0]  COPY_LIMIT_RESET  = 9'd256;

    function automatic logic [3:0] clamp8(input logic [3:0] n);
        clamp8 = (n > MAX_TEXT_LEN) ? MAX_TEXT_LEN : n;
    endfunction

    function automatic logic [7:0] ok_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "O";
            4'd1:    c = "K";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] err_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "E";
            4'd1:    c = "R";
            4'd2:    c = "R";
            4'd3:    c = "O";
            4'd4:    c = "R";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "+CMx ERROR:" with the fourth character given by the caller
    function automatic logic [7:0] cmx_char(input logic [3:0] pos, input logic [7:0] x);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "+";
            4'd1:    c = "C";
            4'd2:    c = "M";
            4'd3:    c = x;
            4'd4:    c = " ";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "R";
            4'd8:    c = "O";
            4'd9:    c = "R";
            4'd10:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/atrlp_byte_ram.sv */
// byte-wide synchronous ram, one write port and one registered read port
module atrlp_byte_ram #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/at_response_line_parser_unit.sv */
// top level of the at response line parser
// Received bytes, and starts and ticks that give no result, are taken in the idle state and
// leave it idle; a start or tick that answers timeout passes through the emit state, and a
// response read through the read-data and emit states, each waiting in the emit state for
// the output register to free up. A line feed that ends a line while a command is armed
// walks the line store through its single read port, one byte per cycle: the scan state
// matches the line's first bytes, up to 11, against echo, prefix and final result texts,
// the decide state passes a final result on through the emit state, and a saved line is
// copied with CR LF into the response store through the copy, CR and LF states. Results
// leave through an output register, so the next beat is taken while a result waits; a
// second result stalls the block until the first one is taken. Configuration writes are taken in every cycle.
`include "at_response_line_parser_unit_macros.svh"

module at_response_line_parser_unit #(
    parameter int LINE_DEPTH = 128,
    parameter int RESP_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  atrlp_pkg::op_t      op,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output atrlp_pkg::kind_t    kind,
    output atrlp_pkg::status_t  status,
    output logic [8:0]          resp_length,
    output logic [7:0]          read_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    import atrlp_pkg::*;

    localparam int LAW  = $clog2(LINE_DEPTH);
    localparam int LCW  = $clog2(LINE_DEPTH + 1);
    localparam int RAW  = $clog2(RESP_DEPTH);
    localparam int RCW  = $clog2(RESP_DEPTH + 1);
    localparam int CMPW = (RCW > 9) ? RCW : 9;
    localparam int SUMW = ((RCW > LCW) ? RCW : LCW) + 2;

    fsm_state_t  state_reg, state_next;

    logic [63:0] prefix_bytes_reg;
    logic [3:0]  prefix_length_reg;
    logic [63:0] echo_bytes_reg;
    logic [3:0]  echo_length_reg;
    logic [15:0] timeout_ticks_reg;
    logic [8:0]  copy_limit_reg;

    logic [LCW-1:0] line_count_reg, line_count_next;
    logic [RCW-1:0] resp_count_reg, resp_count_next;
    logic           cmd_active_reg, cmd_active_next;
    logic           collecting_reg, collecting_next;
    logic [15:0]    tick_count_reg, tick_count_next;

    logic [LCW-1:0] ptr_reg, ptr_next;
    logic           chk_v_reg, chk_v_next;
    logic [3:0]     chk_pos_reg, chk_pos_next;
    match_t         match_reg, match_next;
    logic [RCW-1:0] wr_ptr_reg, wr_ptr_next;
    logic           rd_hit_reg, rd_hit_next;

    kind_t          res_kind_reg, res_kind_next;
    status_t        res_status_reg, res_status_next;
    logic [8:0]     res_len_reg, res_len_next;
    logic [7:0]     res_data_reg, res_data_next;

    logic           out_valid_reg, out_valid_next;
    kind_t          out_kind_reg;
    status_t        out_status_reg;
    logic [8:0]     out_len_reg;
    logic [7:0]     out_data_reg;
    logic           out_load;

    logic           line_we;
    logic [LAW-1:0] line_waddr;
    logic [LAW-1:0] line_raddr;
    logic [7:0]     line_rdata;
    logic           resp_we;
    logic [RAW-1:0] resp_waddr;
    logic [7:0]     resp_wdata;
    logic [RAW-1:0] resp_raddr;
    logic [7:0]     resp_rdata;

    logic           in_acc;
    logic           out_free;
    logic [15:0]    tick_inc;
    logic [CMPW-1:0] rep_len;
    logic [LCW-1:0] scan_n;
    logic [LCW-1:0] rd_end;
    logic           rd_issue;
    logic [3:0]     el;
    logic [3:0]     pl;
    logic           is_echo;
    logic           is_ok;
    logic           is_err;
    logic           pre_hit;
    logic           do_save;
    logic           fits;

    atrlp_byte_ram #(
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (rx_byte),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    atrlp_byte_ram #(
        .DEPTH (RESP_DEPTH)
    ) u_resp_ram (
        .clk   (clk),
        .we    (resp_we),
        .waddr (resp_waddr),
        .wdata (resp_wdata),
        .raddr (resp_raddr),
        .rdata (resp_rdata)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign status      = out_status_reg;
    assign resp_length = out_len_reg;
    assign read_data   = out_data_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign tick_inc = tick_count_reg + 16'd1;
    assign rep_len  = (CMPW'(resp_count_reg) < CMPW'(copy_limit_reg)) ?
                      CMPW'(resp_count_reg) : CMPW'(copy_limit_reg);
    assign scan_n   = (line_count_reg >= LCW'(CMX_LEN)) ? LCW'(CMX_LEN) : line_count_reg;
    assign rd_end   = (state_reg == S_SCAN) ? scan_n : line_count_reg;
    assign rd_issue = ptr_reg < rd_end;

    assign el      = clamp8(echo_length_reg);
    assign pl      = clamp8(prefix_length_reg);
    assign is_echo = (el != 4'd0) && (line_count_reg == LCW'(el)) && match_reg.echo;
    assign is_ok   = (line_count_reg == LCW'(OK_LEN)) && match_reg.ok;
    assign is_err  = ((line_count_reg == LCW'(ERR_LEN)) && match_reg.err) ||
                     ((line_count_reg >= LCW'(CMX_LEN)) && (match_reg.cme || match_reg.cms));
    assign pre_hit = (line_count_reg >= LCW'(pl)) && match_reg.prefix;
    assign do_save = (pl == 4'd0) || pre_hit || collecting_reg;
    assign fits    = (SUMW'(resp_count_reg) + SUMW'(line_count_reg) + SUMW'(2))
                     <= SUMW'(RESP_DEPTH);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op)
                        OP_RX_BYTE:
                        begin
                            if ((rx_byte == CHAR_LF) && (line_count_reg != '0) && cmd_active_reg)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_START:
                        begin
                            if (timeout_ticks_reg == 16'd0)
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        OP_TICK:
                        begin
                            if (cmd_active_reg && (tick_inc >= timeout_ticks_reg))
                            begin
                                state_next = S_EMIT;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = S_RDATA;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!rd_issue && !chk_v_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (is_echo)
                begin
                    state_next = S_IDLE;
                end
                else if (is_ok || is_err)
                begin
                    state_next = S_EMIT;
                end
                else if (do_save && fits)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                if (!rd_issue && !chk_v_reg)
                begin
                    state_next = S_CR;
                end
            end
            S_CR:
            begin
                state_next = S_LF;
            end
            S_LF:
            begin
                state_next = S_IDLE;
            end
            S_RDATA:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        line_count_next = line_count_reg;
        resp_count_next = resp_count_reg;
        cmd_active_next = cmd_active_reg;
        collecting_next = collecting_reg;
        tick_count_next = tick_count_reg;
        ptr_next        = ptr_reg;
        chk_v_next      = 1'b0;
        chk_pos_next    = chk_pos_reg;
        match_next      = match_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_hit_next     = rd_hit_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        res_len_next    = res_len_reg;
        res_data_next   = res_data_reg;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        line_we         = 1'b0;
        line_waddr      = line_count_reg[LAW-1:0];
        line_raddr      = ptr_reg[LAW-1:0];
        resp_we         = 1'b0;
        resp_waddr      = wr_ptr_reg[RAW-1:0];
        resp_wdata      = line_rdata;
        resp_raddr      = RAW'(read_index);

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op)
                        OP_RX_BYTE:
                        begin
                            if (rx_byte == CHAR_CR)
                            begin
                                line_count_next = line_count_reg;
                            end
                            else if (rx_byte == CHAR_LF)
                            begin
                                if (line_count_reg != '0)
                                begin
                                    if (cmd_active_reg)
                                    begin
                                        ptr_next   = '0;
                                        match_next = '1;
                                    end
                                    else
                                    begin
                                        line_count_next = '0;
                                    end
                                end
                            end
                            else if (line_count_reg < LCW'(LINE_DEPTH))
                            begin
                                line_we         = 1'b1;
                                line_count_next = line_count_reg + LCW'(1);
                            end
                            else
                            begin
                                // overlong line, drop it
                                line_count_next = '0;
                            end
                        end
                        OP_START:
                        begin
                            resp_count_next = '0;
                            collecting_next = 1'b0;
                            tick_count_next = '0;
                            res_kind_next   = KIND_STATUS;
                            res_status_next = STAT_TIMEOUT;
                            res_len_next    = '0;
                            res_data_next   = '0;
                            cmd_active_next = (timeout_ticks_reg != 16'd0);
                        end
                        OP_TICK:
                        begin
                            if (cmd_active_reg)
                            begin
                                tick_count_next = tick_inc;
                                res_kind_next   = KIND_STATUS;
                                res_status_next = STAT_TIMEOUT;
                                res_len_next    = '0;
                                res_data_next   = '0;
                                if (tick_inc >= timeout_ticks_reg)
                                begin
                                    cmd_active_next = 1'b0;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            rd_hit_next = CMPW'(read_index) < rep_len;
                        end
                        default:
                        begin
                            rd_hit_next = rd_hit_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                chk_v_next   = rd_issue;
                chk_pos_next = ptr_reg[3:0];
                if (rd_issue)
                begin
                    ptr_next = ptr_reg + LCW'(1);
                end
                if (chk_v_reg)
                begin
                    if ((chk_pos_reg < el) &&
                        (line_rdata != echo_bytes_reg[{chk_pos_reg[2:0], 3'b000} +: 8]))
                    begin
                        match_next.echo = 1'b0;
                    end
                    if ((chk_pos_reg < pl) &&
                        (line_rdata != prefix_bytes_reg[{chk_pos_reg[2:0], 3'b000} +: 8]))
                    begin
                        match_next.prefix = 1'b0;
                    end
                    if ((chk_pos_reg < OK_LEN) && (line_rdata != ok_char(chk_pos_reg)))
                    begin
                        match_next.ok = 1'b0;
                    end
                    if ((chk_pos_reg < ERR_LEN) && (line_rdata != err_char(chk_pos_reg)))
                    begin
                        match_next.err = 1'b0;
                    end
                    if ((chk_pos_reg < CMX_LEN) && (line_rdata != cmx_char(chk_pos_reg, "E")))
                    begin
                        match_next.cme = 1'b0;
                    end
                    if ((chk_pos_reg < CMX_LEN) && (line_rdata != cmx_char(chk_pos_reg, "S")))
                    begin
                        match_next.cms = 1'b0;
                    end
                end
            end
            S_DECIDE:
            begin
                res_kind_next = KIND_STATUS;
                res_data_next = '0;
                res_len_next  = '0;
                if (is_echo)
                begin
                    line_count_next = '0;
                end
                else if (is_ok)
                begin
                    cmd_active_next = 1'b0;
                    res_status_next = STAT_OK;
                    res_len_next    = rep_len[8:0];
                    line_count_next = '0;
                end
                else if (is_err)
                begin
                    cmd_active_next = 1'b0;
                    res_status_next = STAT_ERROR;
                    line_count_next = '0;
                end
                else
                begin
                    if ((pl != 4'd0) && pre_hit)
                    begin
                        collecting_next = 1'b1;
                    end
                    if (do_save && fits)
                    begin
                        ptr_next    = '0;
                        wr_ptr_next = resp_count_reg;
                    end
                    else
                    begin
                        line_count_next = '0;
                    end
                end
            end
            S_COPY:
            begin
                chk_v_next = rd_issue;
                if (rd_issue)
                begin
                    ptr_next = ptr_reg + LCW'(1);
                end
                if (chk_v_reg)
                begin
                    resp_we     = 1'b1;
                    wr_ptr_next = wr_ptr_reg + RCW'(1);
                end
            end
            S_CR:
            begin
                resp_we     = 1'b1;
                resp_wdata  = CHAR_CR;
                wr_ptr_next = wr_ptr_reg + RCW'(1);
            end
            S_LF:
            begin
                resp_we         = 1'b1;
                resp_wdata      = CHAR_LF;
                resp_count_next = wr_ptr_reg + RCW'(1);
                line_count_next = '0;
            end
            S_RDATA:
            begin
                res_kind_next   = KIND_READ;
                res_status_next = STAT_OK;
                res_len_next    = '0;
                res_data_next   = rd_hit_reg ? resp_rdata : 8'h00;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            prefix_bytes_reg  <= '0;
            prefix_length_reg <= '0;
            echo_bytes_reg    <= '0;
            echo_length_reg   <= '0;
            timeout_ticks_reg <= TIMEOUT_RESET;
            copy_limit_reg    <= COPY_LIMIT_RESET;
            line_count_reg    <= '0;
            resp_count_reg    <= '0;
            cmd_active_reg    <= 1'b0;
            collecting_reg    <= 1'b0;
            tick_count_reg    <= '0;
            ptr_reg           <= '0;
            chk_v_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_count_reg <= line_count_next;
            resp_count_reg <= resp_count_next;
            cmd_active_reg <= cmd_active_next;
            collecting_reg <= collecting_next;
            tick_count_reg <= tick_count_next;
            ptr_reg        <= ptr_next;
            chk_v_reg      <= chk_v_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PREFIX_BYTES:  prefix_bytes_reg  <= cfg_data;
                    CFG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[3:0];
                    CFG_ECHO_BYTES:    echo_bytes_reg    <= cfg_data;
                    CFG_ECHO_LENGTH:   echo_length_reg   <= cfg_data[3:0];
                    CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                    CFG_COPY_LIMIT:    copy_limit_reg    <= cfg_data[8:0];
                    default:           copy_limit_reg    <= copy_limit_reg;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        chk_pos_reg    <= chk_pos_next;
        match_reg      <= match_next;
        wr_ptr_reg     <= wr_ptr_next;
        rd_hit_reg     <= rd_hit_next;
        res_kind_reg   <= res_kind_next;
        res_status_reg <= res_status_next;
        res_len_reg    <= res_len_next;
        res_data_reg   <= res_data_next;
        if (out_load)
        begin
            out_kind_reg   <= res_kind_reg;
            out_status_reg <= res_status_reg;
            out_len_reg    <= res_len_reg;
            out_data_reg   <= res_data_reg;
        end
    end

    `ATRLP_ASSERT_NOW(a_line_count_bound, 1'b1, line_count_reg <= LCW'(LINE_DEPTH), "line count beyond line store depth")
    `ATRLP_ASSERT_NOW(a_resp_write_bound, resp_we, wr_ptr_reg < RCW'(RESP_DEPTH), "response write beyond response store")
    `ATRLP_ASSERT_NOW(a_resp_count_bound, 1'b1, resp_count_reg <= RCW'(RESP_DEPTH), "response count beyond response store depth")
    `ATRLP_ASSERT_NEXT(a_final_disarms, (state_reg == S_DECIDE) && !is_echo && (is_ok || is_err), !cmd_active_reg && (state_reg == S_EMIT), "final result line did not disarm the command")
    `ATRLP_ASSERT_NEXT(a_emit_loads, (state_reg == S_EMIT) && out_free, out_valid_reg && (state_reg == S_IDLE), "pending result not moved to the output register")

endmodule

/* tb/tb_top.sv */
// testbench of the at response line parser: directed table and random command traffic
`timescale 1ns / 100ps

module tb_top;
    import atrlp_pkg::*;

    localparam int LINE_DEPTH = 128;
    localparam int RESP_DEPTH = 256;
    localparam int SETTLE = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BEATS = 150;

    typedef struct packed {
        kind_t      kind;
        status_t    st;
        logic [8:0] len;
        logic [7:0] data;
    } resp_t;

    typedef struct packed {
        logic [63:0] pfx;
        logic [3:0]  plen;
        logic [63:0] echo;
        logic [3:0]  elen;
        logic [15:0] tmo;
        logic [8:0]  cap;
    } cfg_set_t;

    typedef struct {
        bit          is_cfg;
        op_t         op;
        logic [7:0]  b;
        logic [7:0]  ix;
        cfg_idx_t    reg_id;
        logic [63:0] val;
        bit          typed;
        resp_t       want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    op_t         op;
    logic [7:0]  rx_byte;
    logic [7:0]  read_index;
    logic        out_valid;
    logic        out_stall;
    kind_t       kind;
    status_t     status;
    logic [8:0]  resp_length;
    logic [7:0]  read_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_data;

    // parser state as the block should hold it
    logic [7:0]  ln_buf [LINE_DEPTH];
    int          ln_cnt;
    logic [7:0]  rs_buf [RESP_DEPTH];
    int          rs_cnt;
    bit          armed;
    bit          gathering;
    int          ticks;
    logic [63:0] pfx_bytes;
    logic [3:0]  pfx_len;
    logic [63:0] echo_txt;
    logic [3:0]  echo_len;
    logic [15:0] tmo;
    logic [8:0]  cap;

    resp_t       expq [$];
    logic [7:0]  txt_q [$];
    plan_row_t   plan [$];
    int          fail_count;
    int          beats_fed;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;

    at_response_line_parser_unit #(
        .LINE_DEPTH (LINE_DEPTH),
        .RESP_DEPTH (RESP_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .rx_byte     (rx_byte),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .status      (status),
        .resp_length (resp_length),
        .read_data   (read_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int text_len(logic [3:0] n);
        return (n > 4'd8) ? 8 : int'(n);
    endfunction

    function automatic int shown_len();
        return (rs_cnt < int'(cap)) ? rs_cnt : int'(cap);
    endfunction

    function automatic bit line_is_text(string s, bit whole);
        if (ln_cnt < s.len() || (whole && ln_cnt != s.len()))
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (ln_buf[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit line_led_by(logic [63:0] pk, int n);
        if (ln_cnt < n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (ln_buf[i] != pk[8*i +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit step_parser(input op_t o, input logic [7:0] b,
                                       input logic [7:0] ix, output resp_t r);
        bit hit;
        bit keep;
        int el;
        int pl;
        hit = 1'b0;
        keep = 1'b0;
        el = text_len(echo_len);
        pl = text_len(pfx_len);
        r = '{KIND_STATUS, STAT_OK, 9'd0, 8'd0};
        case (o)
            OP_RX_BYTE:
            begin
                if (b == CHAR_LF)
                begin
                    if (ln_cnt > 0)
                    begin
                        if (armed && !(el != 0 && ln_cnt == el && line_led_by(echo_txt, el)))
                        begin
                            if (line_is_text("OK", 1'b1))
                            begin
                                armed = 1'b0;
                                r.len = 9'(shown_len());
                                hit = 1'b1;
                            end
                            else if (line_is_text("ERROR", 1'b1)
                                     || line_is_text("+CME ERROR:", 1'b0)
                                     || line_is_text("+CMS ERROR:", 1'b0))
                            begin
                                armed = 1'b0;
                                r.st = STAT_ERROR;
                                hit = 1'b1;
                            end
                            else if (pl == 0)
                                keep = 1'b1;
                            else if (line_led_by(pfx_bytes, pl))
                            begin
                                keep = 1'b1;
                                gathering = 1'b1;
                            end
                            else
                                keep = gathering;
                        end
                        if (keep && rs_cnt + ln_cnt + 2 <= RESP_DEPTH)
                        begin
                            for (int i = 0; i < ln_cnt; i++)
                                rs_buf[rs_cnt + i] = ln_buf[i];
                            rs_cnt += ln_cnt;
                            rs_buf[rs_cnt] = CHAR_CR;
                            rs_buf[rs_cnt + 1] = CHAR_LF;
                            rs_cnt += 2;
                        end
                        ln_cnt = 0;
                    end
                end
                else if (b != CHAR_CR)
                begin
                    if (ln_cnt < LINE_DEPTH)
                    begin
                        ln_buf[ln_cnt] = b;
                        ln_cnt++;
                    end
                    else
                        ln_cnt = 0;
                end
            end
            OP_START:
            begin
                rs_cnt = 0;
                gathering = 1'b0;
                ticks = 0;
                if (tmo == 16'd0)
                begin
                    armed = 1'b0;
                    r.st = STAT_TIMEOUT;
                    hit = 1'b1;
                end
                else
                    armed = 1'b1;
            end
            OP_TICK:
            begin
                if (armed)
                begin
                    ticks = (ticks + 1) & 16'hFFFF;
                    if (ticks >= int'(tmo))
                    begin
                        armed = 1'b0;
                        r.st = STAT_TIMEOUT;
                        hit = 1'b1;
                    end
                end
            end
            default:
            begin
                hit = 1'b1;
                r.kind = KIND_READ;
                r.data = (int'(ix) < shown_len()) ? rs_buf[ix] : 8'd0;
            end
        endcase
        return hit;
    endfunction

    task automatic check_field(string what, int unsigned want, int unsigned seen);
        if (want != seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expq.size() == 0)
            begin
                $display("%0t: result with none expected, actual kind %0d status %0d data %0d",
                         $time, kind, status, read_data);
                fail_count++;
            end
            else
            begin
                e = expq.pop_front();
                check_field("kind", e.kind, kind);
                check_field("status", e.st, status);
                check_field("resp_length", e.len, resp_length);
                check_field("read_data", e.data, read_data);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic send_item(op_t o, logic [7:0] b, logic [7:0] ix);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        rx_byte <= b;
        read_index <= ix;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic feed(op_t o, logic [7:0] b, logic [7:0] ix);
        resp_t r;
        send_item(o, b, ix);
        if (step_parser(o, b, ix, r))
            expq.push_back(r);
        if (!(o == OP_RX_BYTE && b == CHAR_CR))
            beats_fed++;
    endtask

    task automatic drain(int settle);
        in_valid <= 1'b0;
        while (expq.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PREFIX_BYTES:  pfx_bytes = val;
            CFG_PREFIX_LENGTH: pfx_len = val[3:0];
            CFG_ECHO_BYTES:    echo_txt = val;
            CFG_ECHO_LENGTH:   echo_len = val[3:0];
            CFG_TIMEOUT_TICKS: tmo = val[15:0];
            CFG_COPY_LIMIT:    cap = val[8:0];
            default:           ;
        endcase
    endtask

    task automatic load_setting(cfg_set_t s);
        drain(SETTLE);
        set_reg(CFG_PREFIX_BYTES, s.pfx);
        set_reg(CFG_PREFIX_LENGTH, 64'(s.plen));
        set_reg(CFG_ECHO_BYTES, s.echo);
        set_reg(CFG_ECHO_LENGTH, 64'(s.elen));
        set_reg(CFG_TIMEOUT_TICKS, 64'(s.tmo));
        set_reg(CFG_COPY_LIMIT, 64'(s.cap));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_set_t setting_for(int p);
        cfg_set_t s;
        case (p)
            0: s = '{64'h0000_003A_5153_432B, 4'd5, 64'h0000_5153_432B_5441, 4'd6,
                     16'd40, 9'd256};
            1: s = '{64'h0, 4'd0, 64'h0000_0000_0000_5441, 4'd2, 16'd3, 9'd0};
            2: s = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h3F52_4D47_432B_5441, 4'd8,
                     16'd65535, 9'd511};
            3: s = '{64'h3020_3A47_4552_432B, 4'd12, 64'h3F47_4552_432B_5441, 4'd15,
                     16'd25, 9'd17};
            4: s = '{64'h0000_0000_0000_002B, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                     16'd20, 9'd100};
            default: s = '{64'h0000_0049_4D47_432B, 4'd5, 64'h0000_0000_0049_5441, 4'd3,
                           16'd65535, 9'd256};
        endcase
        return s;
    endfunction

    function automatic plan_row_t item_row(op_t o, logic [7:0] b, logic [7:0] ix);
        plan_row_t row;
        row = '{1'b0, o, b, ix, CFG_PREFIX_BYTES, 64'h0, 1'b0,
                '{KIND_STATUS, STAT_OK, 9'd0, 8'd0}};
        return row;
    endfunction

    function automatic plan_row_t typed_row(op_t o, logic [7:0] b, logic [7:0] ix, kind_t k,
                                           status_t st, int len, int data);
        plan_row_t row;
        row = item_row(o, b, ix);
        row.typed = 1'b1;
        row.want = '{k, st, 9'(len), 8'(data)};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [63:0] val);
        plan_row_t row;
        row = item_row(OP_RX_BYTE, 8'h00, 8'h00);
        row.is_cfg = 1'b1;
        row.reg_id = idx;
        row.val = val;
        return row;
    endfunction

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            txt_q.push_back(s[i]);
    endtask

    task automatic add_packed(logic [63:0] pk, int n);
        for (int i = 0; i < n; i++)
            txt_q.push_back(pk[8*i +: 8]);
    endtask

    task automatic add_noise(int n, bit printable);
        repeat (n)
            txt_q.push_back(printable ? 8'($urandom_range(32, 126)) : 8'($urandom));
    endtask

    task automatic send_line();
        foreach (txt_q[i])
            feed(OP_RX_BYTE, txt_q[i], 8'($urandom));
        if ($urandom_range(0, 99) < 50)
            feed(OP_RX_BYTE, CHAR_CR, 8'($urandom));
        feed(OP_RX_BYTE, CHAR_LF, 8'($urandom));
        txt_q.delete();
    endtask

    task automatic run_command();
        int pick;
        int lim;
        feed(OP_START, 8'($urandom), 8'($urandom));
        if (text_len(echo_len) > 0 && $urandom_range(0, 99) < 60)
        begin
            add_packed(echo_txt, text_len(echo_len));
            send_line();
        end
        repeat ($urandom_range(0, 4))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                add_packed(pfx_bytes, text_len(pfx_len));
                add_noise($urandom_range(0, 10), 1'b1);
            end
            else if (pick < 65)
                add_noise($urandom_range(1, 12), 1'b1);
            else if (pick < 75)
            begin
                case ($urandom_range(0, 4))
                    0: add_str("OKAY");
                    1: add_str("ERRORS");
                    2: add_str("+CME ERROR");
                    3: add_str("ERRO");
                    default: add_str("O");
                endcase
            end
            else if (pick < 88 && pick >= 82)
                add_noise($urandom_range(120, 135), 1'b1);
            else if (pick >= 88)
                add_noise($urandom_range(1, 20), 1'b0);
            send_line();
            if ($urandom_range(0, 99) < 15)
                feed(OP_TICK, 8'($urandom), 8'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
            add_str("OK");
        else if (pick < 60)
            add_str("ERROR");
        else if (pick < 70)
            add_str("+CME ERROR:");
        else if (pick < 80)
            add_str("+CMS ERROR:");
        if (pick >= 60 && pick < 80)
            add_noise($urandom_range(0, 4), 1'b1);
        if (pick < 80)
            send_line();
        else if (pick < 92)
            repeat ((tmo != 16'd0 && tmo <= 16'd64) ? int'(tmo) : 5)
                feed(OP_TICK, 8'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 3))
        begin
            lim = shown_len() + 2;
            if (lim > 255)
                lim = 255;
            if ($urandom_range(0, 99) < 70)
                feed(OP_READ, 8'($urandom), 8'($urandom_range(0, lim)));
            else
                feed(OP_READ, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        resp_t r;
        bit got;
        bit paused;
        int mark;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_RX_BYTE;
        rx_byte = 8'h00;
        read_index = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = CFG_PREFIX_BYTES;
        cfg_data = 64'h0;
        hold_req = 1'b0;
        fail_count = 0;
        beats_fed = 0;
        paused = 1'b0;
        ln_cnt = 0;
        rs_cnt = 0;
        armed = 1'b0;
        gathering = 1'b0;
        ticks = 0;
        pfx_bytes = 64'h0;
        pfx_len = 4'd0;
        echo_txt = 64'h0;
        echo_len = 4'd0;
        tmo = TIMEOUT_RESET;
        cap = COPY_LIMIT_RESET;
        send_idle_pct = 14;
        recv_idle_pct = 59;

        plan.push_back(typed_row(OP_READ, 8'h00, 8'h00, KIND_READ, STAT_OK, 0, 0));
        plan.push_back(typed_row(OP_READ, 8'hFF, 8'hFF, KIND_READ, STAT_OK, 0, 0));
        plan.push_back(item_row(OP_TICK, 8'h55, 8'hAA));
        plan.push_back(item_row(OP_RX_BYTE, 8'hFF, 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, CHAR_CR, 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, CHAR_LF, 8'h00));
        plan.push_back(item_row(OP_START, 8'h00, 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, "O", 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, "K", 8'h00));
        plan.push_back(typed_row(OP_RX_BYTE, CHAR_LF, 8'h00, KIND_STATUS, STAT_OK, 0, 0));
        plan.push_back(item_row(OP_START, 8'h00, 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, "A", 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, CHAR_LF, 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, CHAR_LF, 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, "O", 8'h00));
        plan.push_back(item_row(OP_RX_BYTE, "K", 8'h00));
        plan.push_back(typed_row(OP_RX_BYTE, CHAR_LF, 8'h00, KIND_STATUS, STAT_OK, 3, 0));
        plan.push_back(typed_row(OP_READ, 8'h00, 8'd0, KIND_READ, STAT_OK, 0, 8'h41));
        plan.push_back(typed_row(OP_READ, 8'h00, 8'd2, KIND_READ, STAT_OK, 0, 8'h0A));
        plan.push_back(typed_row(OP_READ, 8'h00, 8'd3, KIND_READ, STAT_OK, 0, 0));
        plan.push_back(cfg_row(CFG_TIMEOUT_TICKS, 64'd0));
        plan.push_back(typed_row(OP_START, 8'h00, 8'h00, KIND_STATUS, STAT_TIMEOUT, 0, 0));
        plan.push_back(cfg_row(CFG_TIMEOUT_TICKS, 64'd2));
        plan.push_back(item_row(OP_START, 8'h00, 8'h00));
        plan.push_back(item_row(OP_TICK, 8'h00, 8'h00));
        plan.push_back(typed_row(OP_TICK, 8'h00, 8'h00, KIND_STATUS, STAT_TIMEOUT, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain(SETTLE);
                set_reg(plan[i].reg_id, plan[i].val);
                cfg_valid <= 1'b0;
            end
            else
            begin
                send_item(plan[i].op, plan[i].b, plan[i].ix);
                got = step_parser(plan[i].op, plan[i].b, plan[i].ix, r);
                if (plan[i].typed)
                    expq.push_back(plan[i].want);
                else if (got)
                    expq.push_back(r);
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            load_setting(setting_for(p));
            send_idle_pct = (p < 2) ? 14 : (p < 4) ? 59 : 0;
            recv_idle_pct = (p < 2) ? 59 : (p < 4) ? 14 : 0;
            mark = beats_fed;
            if (p == 4)
            begin
                hold_req = 1'b1;
                repeat (12) feed(OP_READ, 8'($urandom), 8'($urandom));
            end
            while (beats_fed - mark < PHASE_BEATS)
            begin
                if ($urandom_range(0, 99) < 15)
                    repeat ($urandom_range(1, 8))
                        feed(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                else
                    run_command();
                if (p == 3 && !paused && beats_fed - mark >= PHASE_BEATS / 2)
                begin
                    drain(0);
                    paused = 1'b1;
                end
            end
        end

        drain(SETTLE);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
